/* rtl/complex_arith_unit_macros.svh */
// Assertion helpers for the complex arithmetic unit checkers.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Same-cycle implication, off while in reset
`define CAU_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers reset itself
`define CAU_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cau_pkg.sv */
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int QUO_WIDTH  = DATA_WIDTH;
  localparam int NUM_WIDTH  = PROD_WIDTH + FRAC_BITS;
  localparam int TOP_WIDTH  = NUM_WIDTH - QUO_WIDTH;
  localparam int CMP_WIDTH  = (TOP_WIDTH > PROD_WIDTH) ? TOP_WIDTH : PROD_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    word_t val;
    logic  sat;
  } clip_t;

  // One divider lane: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic                  neg;
    logic                  ovf;
    logic [PROD_WIDTH-1:0] rem;
    logic [QUO_WIDTH-1:0]  quo;
  } div_lane_t;

  // Everything one item carries along the cell chain
  typedef struct packed {
    logic                  valid;
    op_t                   op;
    logic                  dz;
    word_t                 alt_real;
    word_t                 alt_imag;
    logic                  alt_sat;
    logic [PROD_WIDTH-1:0] den;
    div_lane_t             re;
    div_lane_t             im;
  } cell_t;

  // Clip a wide signed value to the word range
  function automatic clip_t clip_word(input logic signed [SUM_WIDTH-1:0] v);
    clip_t r;
    logic signed [SUM_WIDTH-1:0] hi;
    logic signed [SUM_WIDTH-1:0] lo;
    hi = SUM_WIDTH'(WORD_MAX);
    lo = SUM_WIDTH'(WORD_MIN);
    if (v > hi) begin
      r.val = WORD_MAX;
      r.sat = 1'b1;
    end else if (v < lo) begin
      r.val = WORD_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = v[DATA_WIDTH-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/cau_prep.sv */
module cau_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  cau_pkg::op_t                  in_op,
  input  logic [cau_pkg::DATA_WIDTH-1:0] in_a_real,
  input  logic [cau_pkg::DATA_WIDTH-1:0] in_a_imag,
  input  logic [cau_pkg::DATA_WIDTH-1:0] in_b_real,
  input  logic [cau_pkg::DATA_WIDTH-1:0] in_b_imag,
  output cau_pkg::cell_t                out
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PROD_WIDTH;
  localparam int SW = cau_pkg::SUM_WIDTH;
  localparam int NW = cau_pkg::NUM_WIDTH;
  localparam int QW = cau_pkg::QUO_WIDTH;
  localparam int TW = cau_pkg::TOP_WIDTH;
  localparam int CW = cau_pkg::CMP_WIDTH;

  function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic signed [SW-1:0] sval(input logic [PW-1:0] m, input logic n);
    logic signed [SW-1:0] v;
    v = $signed({2'b00, m});
    return n ? -v : v;
  endfunction

  function automatic cau_pkg::clip_t clip_add(input logic signed [DW:0] s);
    cau_pkg::clip_t r;
    if (s[DW] != s[DW-1]) begin
      r.val = s[DW] ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = s[DW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic cau_pkg::div_lane_t lane_init(input logic signed [SW-1:0] num,
                                                   input logic [PW-1:0] den);
    cau_pkg::div_lane_t l;
    logic [SW-1:0] am;
    logic [NW-1:0] nfull;
    logic [TW-1:0] top;
    am    = num[SW-1] ? -num : num;
    nfull = NW'(am[PW-1:0]) << cau_pkg::FRAC_BITS;
    top   = nfull[NW-1:QW];
    l.neg = num[SW-1];
    l.ovf = CW'(top) >= CW'(den);
    l.rem = PW'(top);
    l.quo = nfull[QW-1:0];
    return l;
  endfunction

  // Stage 1: add/subtract, operand magnitudes
  logic                 s1_valid;
  cau_pkg::op_t         s1_op;
  logic                 s1_dz;
  cau_pkg::clip_t       s1_as_re, s1_as_im;
  logic [DW-1:0]        s1_m_ar, s1_m_ai, s1_m_br, s1_m_bi;
  logic                 s1_n_ar, s1_n_ai, s1_n_br, s1_n_bi;
  logic signed [DW:0]   sum_re, sum_im;

  always_comb begin
    if (in_op == cau_pkg::OP_SUB) begin
      sum_re = $signed({in_a_real[DW-1], in_a_real}) - $signed({in_b_real[DW-1], in_b_real});
      sum_im = $signed({in_a_imag[DW-1], in_a_imag}) - $signed({in_b_imag[DW-1], in_b_imag});
    end else begin
      sum_re = $signed({in_a_real[DW-1], in_a_real}) + $signed({in_b_real[DW-1], in_b_real});
      sum_im = $signed({in_a_imag[DW-1], in_a_imag}) + $signed({in_b_imag[DW-1], in_b_imag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op    <= in_op;
      s1_dz    <= (in_b_real == '0) && (in_b_imag == '0);
      s1_as_re <= clip_add(sum_re);
      s1_as_im <= clip_add(sum_im);
      s1_m_ar  <= mag_of(in_a_real);
      s1_m_ai  <= mag_of(in_a_imag);
      s1_m_br  <= mag_of(in_b_real);
      s1_m_bi  <= mag_of(in_b_imag);
      s1_n_ar  <= in_a_real[DW-1];
      s1_n_ai  <= in_a_imag[DW-1];
      s1_n_br  <= in_b_real[DW-1];
      s1_n_bi  <= in_b_imag[DW-1];
    end
  end

  // Stage 2: magnitude products
  logic                 s2_valid;
  cau_pkg::op_t         s2_op;
  logic                 s2_dz;
  cau_pkg::clip_t       s2_as_re, s2_as_im;
  logic [PW-1:0]        s2_p_rr, s2_p_ii, s2_p_ir, s2_p_ri, s2_d_r, s2_d_i;
  logic                 s2_n_rr, s2_n_ii, s2_n_ir, s2_n_ri;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op    <= s1_op;
      s2_dz    <= s1_dz;
      s2_as_re <= s1_as_re;
      s2_as_im <= s1_as_im;
      s2_p_rr  <= PW'(s1_m_ar) * PW'(s1_m_br);
      s2_p_ii  <= PW'(s1_m_ai) * PW'(s1_m_bi);
      s2_p_ir  <= PW'(s1_m_ai) * PW'(s1_m_br);
      s2_p_ri  <= PW'(s1_m_ar) * PW'(s1_m_bi);
      s2_d_r   <= PW'(s1_m_br) * PW'(s1_m_br);
      s2_d_i   <= PW'(s1_m_bi) * PW'(s1_m_bi);
      s2_n_rr  <= s1_n_ar ^ s1_n_br;
      s2_n_ii  <= s1_n_ai ^ s1_n_bi;
      s2_n_ir  <= s1_n_ai ^ s1_n_br;
      s2_n_ri  <= s1_n_ar ^ s1_n_bi;
    end
  end

  // Stage 3: combine products for multiply and divide
  logic                 s3_valid;
  cau_pkg::op_t         s3_op;
  logic                 s3_dz;
  cau_pkg::clip_t       s3_alt_re, s3_alt_im;
  logic signed [SW-1:0] s3_nr, s3_ni;
  logic [PW-1:0]        s3_den;
  logic signed [SW-1:0] mul_re, mul_im;
  cau_pkg::clip_t       mc_re, mc_im;

  always_comb begin
    mul_re = sval(s2_p_rr >> cau_pkg::FRAC_BITS, s2_n_rr)
           - sval(s2_p_ii >> cau_pkg::FRAC_BITS, s2_n_ii);
    mul_im = sval(s2_p_ir >> cau_pkg::FRAC_BITS, s2_n_ir)
           + sval(s2_p_ri >> cau_pkg::FRAC_BITS, s2_n_ri);
    mc_re  = cau_pkg::clip_word(mul_re);
    mc_im  = cau_pkg::clip_word(mul_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op     <= s2_op;
      s3_dz     <= s2_dz;
      s3_alt_re <= (s2_op == cau_pkg::OP_MUL) ? mc_re : s2_as_re;
      s3_alt_im <= (s2_op == cau_pkg::OP_MUL) ? mc_im : s2_as_im;
      s3_nr     <= sval(s2_p_rr, s2_n_rr) + sval(s2_p_ii, s2_n_ii);
      s3_ni     <= sval(s2_p_ir, s2_n_ir) - sval(s2_p_ri, s2_n_ri);
      s3_den    <= s2_d_r + s2_d_i;
    end
  end

  // Stage 4: divider setup, first item of the cell chain
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.op       <= s3_op;
      out.dz       <= s3_dz;
      out.alt_real <= s3_alt_re.val;
      out.alt_imag <= s3_alt_im.val;
      out.alt_sat  <= s3_alt_re.sat | s3_alt_im.sat;
      out.den      <= s3_den;
      out.re       <= lane_init(s3_nr, s3_den);
      out.im       <= lane_init(s3_ni, s3_den);
    end
  end

endmodule

/* rtl/cau_cell.sv */
module cau_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cau_pkg::cell_t in,
  output cau_pkg::cell_t out
);

  localparam int PW = cau_pkg::PROD_WIDTH;
  localparam int QW = cau_pkg::QUO_WIDTH;

  // One restoring step: shift in the next dividend bit, try to subtract
  function automatic cau_pkg::div_lane_t lane_step(input cau_pkg::div_lane_t l,
                                                   input logic [PW-1:0] den);
    cau_pkg::div_lane_t r;
    logic [PW:0] sh;
    logic [PW:0] diff;
    logic        ge;
    sh    = {l.rem, l.quo[QW-1]};
    diff  = sh - {1'b0, den};
    ge    = sh >= {1'b0, den};
    r.neg = l.neg;
    r.ovf = l.ovf;
    r.rem = ge ? diff[PW-1:0] : sh[PW-1:0];
    r.quo = {l.quo[QW-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.op       <= in.op;
      out.dz       <= in.dz;
      out.alt_real <= in.alt_real;
      out.alt_imag <= in.alt_imag;
      out.alt_sat  <= in.alt_sat;
      out.den      <= in.den;
      out.re       <= lane_step(in.re, in.den);
      out.im       <= lane_step(in.im, in.den);
    end
  end

endmodule

/* rtl/complex_arith_unit.sv */
// Pipeline: 4 setup stages, 32 divider cells, one for each quotient bit,
// and the output register, between input accept and result valid.
// Throughput: one item per cycle for every operation; the whole pipe
// advances together whenever the output register is empty or being taken.
// Reset: rst clears all valid bits; no result is presented until new items.
module complex_arith_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // a_real, a_imag, b_real, b_imag
  input  logic [1:0]   s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // res_real, res_imag
  output logic [1:0]   m_axis_tuser   // div_zero, saturated
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int QW = cau_pkg::QUO_WIDTH;

  logic           en;
  cau_pkg::cell_t chain [QW+1];

  // Whole pipe steps when the output slot frees up
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  cau_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_op     (cau_pkg::op_t'(s_axis_tuser)),
    .in_a_real (s_axis_tdata[0*DW +: DW]),
    .in_a_imag (s_axis_tdata[1*DW +: DW]),
    .in_b_real (s_axis_tdata[2*DW +: DW]),
    .in_b_imag (s_axis_tdata[3*DW +: DW]),
    .out       (chain[0])
  );

  // Divider cells, one quotient bit each
  for (genvar i = 0; i < QW; i++) begin : g_cell
    cau_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .in  (chain[i]),
      .out (chain[i+1])
    );
  end

  // Quotient sign and saturation
  function automatic cau_pkg::clip_t div_final(input cau_pkg::div_lane_t l);
    cau_pkg::clip_t r;
    logic [QW-1:0] lim;
    lim = QW'(1) << (DW - 1);
    r.sat = 1'b0;
    if (l.neg) begin
      if (l.ovf || l.quo > lim) begin
        r.val = cau_pkg::WORD_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = DW'(-l.quo);
      end
    end else begin
      if (l.ovf || l.quo > lim - 1'b1) begin
        r.val = cau_pkg::WORD_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = DW'(l.quo);
      end
    end
    return r;
  endfunction

  cau_pkg::cell_t last;
  cau_pkg::clip_t dq_re, dq_im;
  cau_pkg::word_t res_re, res_im;
  logic           res_dz, res_sat;

  assign last = chain[QW];

  // Result select
  always_comb begin
    dq_re = div_final(last.re);
    dq_im = div_final(last.im);
    res_re  = last.alt_real;
    res_im  = last.alt_imag;
    res_dz  = 1'b0;
    res_sat = last.alt_sat;
    if (last.op == cau_pkg::OP_DIV) begin
      if (last.dz) begin
        res_re  = '0;
        res_im  = '0;
        res_dz  = 1'b1;
        res_sat = 1'b0;
      end else begin
        res_re  = dq_re.val;
        res_im  = dq_im.val;
        res_sat = dq_re.sat | dq_im.sat;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {res_im, res_re};
      m_axis_tuser <= {res_sat, res_dz};
    end
  end

endmodule

/* rtl/cau_checker.sv */
`include "complex_arith_unit_macros.svh"

module cau_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [127:0] s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  logic rr_lim, ri_lim;

  assign rr_lim = (m_axis_tdata[31:0] == 32'h7fffffff) || (m_axis_tdata[31:0] == 32'h80000000);
  assign ri_lim = (m_axis_tdata[63:32] == 32'h7fffffff) || (m_axis_tdata[63:32] == 32'h80000000);

  // Nothing comes out right after reset
  `CAU_ASSERT_RST(a_rst_empty, rst, !m_axis_tvalid, "result valid after reset")

  // Zero divisor gives zero result without saturation
  `CAU_ASSERT(a_dz_zero, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == 64'd0) && !m_axis_tuser[1], "zero divisor result not zero")

  // A saturated item shows a part at a range limit
  `CAU_ASSERT(a_sat_limit, m_axis_tvalid && m_axis_tuser[1], rr_lim || ri_lim, "saturated flag without a clipped part")

  // Input side never blocks while the output is empty
  `CAU_ASSERT(a_ready_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // Stalled result holds
  `CAU_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

/* bench/complex_arith_unit_tb.sv */
module complex_arith_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result
  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        sat;
  } cplx_res_t;

  // Clip a signed value to the 32-bit range, flagging saturation
  function automatic logic [31:0] clip32(input logic signed [129:0] v, inout logic sat);
    if (v > 130'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end else if (v < -130'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Truncate toward zero after dropping the fraction bits
  function automatic logic signed [129:0] trunc_frac(input logic signed [129:0] p);
    logic signed [129:0] m;
    m = (p < 0) ? -p : p;
    m = m >>> cau_pkg::FRAC_BITS;
    return (p < 0) ? -m : m;
  endfunction

  // (num << FRAC_BITS) / den, truncated toward zero
  function automatic logic signed [129:0] frac_quot(input logic signed [129:0] num,
                                                    input logic signed [129:0] den);
    logic signed [129:0] m;
    m = (num < 0) ? -num : num;
    m = (m <<< cau_pkg::FRAC_BITS) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic cplx_res_t cplx_compute(input cau_pkg::op_t op, input logic [31:0] ar_w,
      input logic [31:0] ai_w, input logic [31:0] br_w, input logic [31:0] bi_w);
    cplx_res_t r;
    logic signed [129:0] ar, ai, br, bi, x, y, den;
    ar = 130'(signed'(ar_w));
    ai = 130'(signed'(ai_w));
    br = 130'(signed'(br_w));
    bi = 130'(signed'(bi_w));
    r.dz = 1'b0;
    r.sat = 1'b0;
    case (op)
      cau_pkg::OP_ADD: begin
        x = ar + br;
        y = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        x = ar - br;
        y = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        x = trunc_frac(ar * br) - trunc_frac(ai * bi);
        y = trunc_frac(ai * br) + trunc_frac(ar * bi);
      end
      default: begin
        if (br == 0 && bi == 0) begin
          r.dz = 1'b1;
          x = 0;
          y = 0;
        end else begin
          den = br * br + bi * bi;
          x = frac_quot(ar * br + ai * bi, den);
          y = frac_quot(ai * br - ar * bi, den);
        end
      end
    endcase
    r.re = clip32(x, r.sat);
    r.im = clip32(y, r.sat);
    return r;
  endfunction

  // Holds expected results in issue order and checks outputs against them
  class cplx_scoreboard;
    cplx_res_t pending[$];
    int errors;

    function void note_input(cau_pkg::op_t op, logic [127:0] d);
      pending.push_back(cplx_compute(op, d[31:0], d[63:32], d[95:64], d[127:96]));
    endfunction

    function void check_result(logic [63:0] d, logic [1:0] u);
      cplx_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, d, u);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.re) begin
        $display("%0t: res_real exp %h got %h", $time, e.re, d[31:0]);
        errors++;
      end
      if (d[63:32] !== e.im) begin
        $display("%0t: res_imag exp %h got %h", $time, e.im, d[63:32]);
        errors++;
      end
      if (u[0] !== e.dz) begin
        $display("%0t: div_zero exp %b got %b", $time, e.dz, u[0]);
        errors++;
      end
      if (u[1] !== e.sat) begin
        $display("%0t: saturated exp %b got %b", $time, e.sat, u[1]);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // a_real, a_imag, b_real, b_imag
  logic [1:0]   s_axis_tuser;   // operation
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // res_real, res_imag
  logic [1:0]   m_axis_tuser;   // div_zero, saturated

  cplx_scoreboard sb = new();
  bit stall_free;

  complex_arith_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly short, sometimes long, none during quiet stretches
  function automatic int gap_len();
    int k;
    if (stall_free) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operand word biased toward edges and small values
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(0, 2047)) - 1024) <<< $urandom_range(0, 16);
      4: return 32'($signed($urandom_range(0, 511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; valid stays high between back-to-back items
  task automatic send_item(cau_pkg::op_t op, logic [31:0] ar, logic [31:0] ai,
                           logic [31:0] br, logic [31:0] bi);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {bi, br, ai, ar};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(op, {bi, br, ai, ar});
    @(negedge clk);
  endtask

  // Result side: random backpressure, check at the accepting edge
  initial begin
    int g;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      @(posedge clk);
      if (m_axis_tvalid) sb.check_result(m_axis_tdata, m_axis_tuser);
      @(negedge clk);
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [31:0] edges[6];
    cau_pkg::op_t op;
    int n;
    edges = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000, 32'hffff0000, 32'h1};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = cau_pkg::OP_ADD;
    stall_free = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every operation at the extremes, zero divisor, overflow
    for (int k = 0; k < 4; k++) begin
      op = cau_pkg::op_t'(k);
      send_item(op, edges[0], edges[0], edges[0], edges[0]);
      send_item(op, edges[1], edges[1], edges[1], edges[1]);
      send_item(op, edges[0], edges[1], edges[1], edges[0]);
      send_item(op, edges[3], edges[4], edges[5], edges[2]);
    end
    send_item(cau_pkg::OP_DIV, edges[3], edges[4], edges[2], edges[2]);
    send_item(cau_pkg::OP_DIV, edges[0], edges[1], edges[2], edges[2]);
    send_item(cau_pkg::OP_DIV, edges[0], edges[1], edges[5], edges[2]);
    send_item(cau_pkg::OP_DIV, edges[1], edges[0], edges[2], edges[5]);
    send_item(cau_pkg::OP_MUL, edges[1], edges[2], edges[1], edges[2]);
    send_item(cau_pkg::OP_DIV, edges[1], edges[1], edges[5], edges[5]);

    // Random operands, with quiet stretches to run the pipe at full rate
    for (n = 0; n < 1350; n++) begin
      if (n % 200 == 0) stall_free = ($urandom_range(0, 2) == 0);
      op = cau_pkg::op_t'($urandom_range(0, 3));
      send_item(op, pick_word(), pick_word(), pick_word(), pick_word());
    end
    s_axis_tvalid <= 1'b0;
    stall_free = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
